[sv/bfpa_pkg.sv]
// ----------------------------------------------------------------------------
// bfpa_pkg
// Shared types, constants and controller/datapath interface for the
// best-fit page allocator.
// ----------------------------------------------------------------------------
package bfpa_pkg;

  // sizing of the heap
  localparam int MAX_PAGES    = 256;
  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;

  localparam int PAGE_W  = $clog2(MAX_PAGES);      // page index
  localparam int PTR_W   = PAGE_W + 1;             // page count, 0..MAX_PAGES
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int BYTES_W = 20;
  localparam int OFF_W   = 20;
  localparam int WORD_W  = PTR_W + 1;              // chunk length and free flag

  // smallest remainder that is split off as its own free chunk
  localparam int SPLIT_MIN = (HEADER_BYTES + PAGE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;

  // request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef struct packed {
    logic                 action;
    logic [BYTES_W-1:0]   request_bytes;
    logic [7:0]           chunk_page;
  } bfpa_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           block_page;
    logic [OFF_W-1:0]     user_offset;
    logic [8:0]           heap_top;
  } bfpa_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK,
    S_DECIDE,
    S_SPLIT,
    S_FRD,
    S_FCHK,
    S_FNX,
    S_FNXCHK,
    S_FPREV,
    S_FSCAN,
    S_FQCHK,
    S_FEND,
    S_DONE
  } bfpa_state_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic walk;
    logic wr_best;
    logic wr_split;
    logic append;
    logic set_nomem;
    logic set_badfree;
    logic rd_p;
    logic chk_p;
    logic rd_nx;
    logic merge_nx;
    logic q_init;
    logic q_dec;
    logic rd_q;
    logic merge_q;
    logic fin_free;
    logic emit;
  } bfpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;
    logic found;
    logic split_ok;
    logic nomem;
    logic p_ok;
    logic rd_free;
    logic nx_ok;
    logic p_zero;
    logic q_stop;
    logic out_busy;
  } bfpa_stat_t;

endpackage

[sv/bfpa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfpa_ctrl
// Sequencer for allocate (best-fit walk, split or append) and free
// (neighbour merge, backward head search, heap top shrink).
// ----------------------------------------------------------------------------
module bfpa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_action,
  output logic               req_ready,
  input  bfpa_pkg::bfpa_stat_t stat,
  output bfpa_pkg::bfpa_cmd_t  cmd
);
  import bfpa_pkg::*;

  bfpa_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = (req_action == ACT_FREE) ? S_FRD : S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.found) begin
          cmd.wr_best = 1'b1;
          state_next  = stat.split_ok ? S_SPLIT : S_DONE;
        end else if (stat.nomem) begin
          cmd.set_nomem = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.append = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SPLIT: begin
        cmd.wr_split = 1'b1;
        state_next   = S_DONE;
      end
      S_FRD: begin
        if (stat.p_ok) begin
          cmd.rd_p   = 1'b1;
          state_next = S_FCHK;
        end else begin
          cmd.set_badfree = 1'b1;
          state_next      = S_DONE;
        end
      end
      S_FCHK: begin
        if (stat.rd_free) begin
          cmd.set_badfree = 1'b1;
          state_next      = S_DONE;
        end else begin
          cmd.chk_p  = 1'b1;
          state_next = S_FNX;
        end
      end
      S_FNX: begin
        if (stat.nx_ok) begin
          cmd.rd_nx  = 1'b1;
          state_next = S_FNXCHK;
        end else begin
          state_next = S_FPREV;
        end
      end
      S_FNXCHK: begin
        cmd.merge_nx = 1'b1;
        state_next   = S_FPREV;
      end
      S_FPREV: begin
        if (stat.p_zero) begin
          state_next = S_FEND;
        end else begin
          cmd.q_init = 1'b1;
          state_next = S_FSCAN;
        end
      end
      S_FSCAN: begin
        if (stat.q_stop) begin
          cmd.rd_q   = 1'b1;
          state_next = S_FQCHK;
        end else begin
          cmd.q_dec = 1'b1;
        end
      end
      S_FQCHK: begin
        cmd.merge_q = 1'b1;
        state_next  = S_FEND;
      end
      S_FEND: begin
        cmd.fin_free = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/bfpa_dp.sv]
// ----------------------------------------------------------------------------
// bfpa_dp
// Chunk table (length and free flag memory, head flags), heap top,
// best-fit tracking, free bookkeeping and the result register.
// ----------------------------------------------------------------------------
module bfpa_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  bfpa_pkg::bfpa_req_t  req_item,
  input  bfpa_pkg::bfpa_cmd_t  cmd,
  output bfpa_pkg::bfpa_stat_t stat,
  output logic                 res_valid,
  input  logic                 res_ready,
  output bfpa_pkg::bfpa_res_t  res_item
);
  import bfpa_pkg::*;

  localparam int SUM_W = BYTES_W + 1;

  // chunk table
  logic [WORD_W-1:0]    mem [MAX_PAGES];
  logic [MAX_PAGES-1:0] head;
  logic [WORD_W-1:0]    rd_word;

  // working registers
  logic [PTR_W-1:0]  need, p, nx, len, best, best_len, top, eval_addr;
  logic [PAGE_W-1:0] q;
  logic              found, hd_q;
  logic [1:0]        res_status;
  logic [PTR_W-1:0]  res_page;
  logic              res_has_page;

  logic [PTR_W-1:0]  rd_len;
  logic              rd_free;
  logic              walk_done, end_top, q_head;
  logic [PTR_W-1:0]  split_page, rest;
  logic [SUM_W-1:0]  need_sum;
  logic [PTR_W-1:0]  need_calc;

  logic              wr_en, rd_en;
  logic [PAGE_W-1:0] wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_word;

  assign rd_len     = rd_word[WORD_W-1:1];
  assign rd_free    = rd_word[0];
  assign walk_done  = (p >= top);
  assign rest       = best_len - need;
  assign split_page = best + need;
  assign end_top    = ({1'b0, p} + {1'b0, len}) >= {1'b0, top};
  assign q_head     = head[q];

  // pages needed by an allocate
  always_comb begin
    need_sum  = {1'b0, req_item.request_bytes} + SUM_W'(HEADER_BYTES + PAGE_BYTES - 1);
    need_calc = PTR_W'(need_sum >> PAGE_SH);
    if (need_calc == '0) need_calc = PTR_W'(1);
  end

  // status to controller
  always_comb begin
    stat.walk_done = walk_done;
    stat.found     = found;
    stat.split_ok  = (rest >= PTR_W'(SPLIT_MIN));
    stat.nomem     = ({1'b0, need} > ((PTR_W+1)'(MAX_PAGES) - {1'b0, top}));
    stat.p_ok      = (p < top) && head[p[PAGE_W-1:0]];
    stat.rd_free   = rd_free;
    stat.nx_ok     = (nx < top) && head[nx[PAGE_W-1:0]];
    stat.p_zero    = (p == '0);
    stat.q_stop    = q_head || (q == '0);
    stat.out_busy  = res_valid && !res_ready;
  end

  // memory port selection
  always_comb begin
    wr_en   = cmd.wr_best | cmd.wr_split | cmd.append | cmd.fin_free;
    wr_addr = p[PAGE_W-1:0];
    wr_word = {len, 1'b1};
    if (cmd.wr_best) begin
      wr_addr = best[PAGE_W-1:0];
      wr_word = {(stat.split_ok ? need : best_len), 1'b0};
    end else if (cmd.wr_split) begin
      wr_addr = split_page[PAGE_W-1:0];
      wr_word = {rest, 1'b1};
    end else if (cmd.append) begin
      wr_addr = top[PAGE_W-1:0];
      wr_word = {need, 1'b0};
    end
    rd_en   = (cmd.walk && !walk_done) | cmd.rd_p | cmd.rd_nx | cmd.rd_q;
    rd_addr = p[PAGE_W-1:0];
    if (cmd.rd_nx) rd_addr = nx[PAGE_W-1:0];
    else if (cmd.rd_q) rd_addr = q;
  end

  // chunk length and free flag memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_word;
    if (rd_en) rd_word <= mem[rd_addr];
  end

  // chunk head flags
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      if (cmd.wr_split) head[split_page[PAGE_W-1:0]] <= 1'b1;
      if (cmd.append) head[top[PAGE_W-1:0]] <= 1'b1;
      if (cmd.merge_nx && rd_free) head[nx[PAGE_W-1:0]] <= 1'b0;
      if (cmd.merge_q && q_head && rd_free) head[p[PAGE_W-1:0]] <= 1'b0;
      if (cmd.fin_free && end_top) head[p[PAGE_W-1:0]] <= 1'b0;
    end
  end

  // heap top and best-fit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      top   <= '0;
      found <= 1'b0;
      hd_q  <= 1'b0;
    end else begin
      if (cmd.start) begin
        found <= 1'b0;
        hd_q  <= 1'b0;
      end
      if (cmd.walk) begin
        hd_q <= walk_done ? 1'b0 : head[p[PAGE_W-1:0]];
        if (hd_q && rd_free && (rd_len >= need) && (!found || (rd_len < best_len)))
          found <= 1'b1;
      end
      if (cmd.append) top <= top + need;
      if (cmd.fin_free && end_top) top <= p;
    end
  end

  // walk pointer, best chunk and free bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      need <= need_calc;
      p    <= (req_item.action == ACT_FREE) ? PTR_W'(req_item.chunk_page) : '0;
    end
    if (cmd.walk) begin
      p         <= p + PTR_W'(1);
      eval_addr <= p;
      if (hd_q && rd_free && (rd_len >= need) && (!found || (rd_len < best_len))) begin
        best     <= eval_addr;
        best_len <= rd_len;
      end
    end
    if (cmd.chk_p) begin
      len <= rd_len;
      nx  <= p + rd_len;
    end
    if (cmd.merge_nx && rd_free) len <= len + rd_len;
    if (cmd.q_init) q <= PAGE_W'(p - PTR_W'(1));
    if (cmd.q_dec) q <= q - PAGE_W'(1);
    if (cmd.merge_q && q_head && rd_free) begin
      len <= rd_len + len;
      p   <= PTR_W'(q);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.wr_best) begin
      res_status   <= ST_OK;
      res_page     <= best;
      res_has_page <= 1'b1;
    end else if (cmd.append) begin
      res_status   <= ST_OK;
      res_page     <= top;
      res_has_page <= 1'b1;
    end else if (cmd.set_nomem) begin
      res_status   <= ST_NOMEM;
      res_page     <= '0;
      res_has_page <= 1'b0;
    end else if (cmd.set_badfree) begin
      res_status   <= ST_BADFREE;
      res_page     <= '0;
      res_has_page <= 1'b0;
    end else if (cmd.fin_free) begin
      res_status   <= ST_OK;
      res_page     <= '0;
      res_has_page <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.emit) res_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_item.status      <= res_status;
      res_item.block_page  <= res_page[7:0];
      res_item.user_offset <= res_has_page ?
        OFF_W'((32'(res_page) << PAGE_SH) + 32'(HEADER_BYTES)) : '0;
      res_item.heap_top    <= 9'(top);
    end
  end

endmodule

[sv/best_fit_page_allocator_unit.sv]
// Best-fit page allocator: one request (allocate or free) is taken at a time and
// answered with exactly one result. An allocate scans the chunk table page by page
// through the length memory, one page per cycle, up to the heap top. A free checks
// the chunk, merges it with a free next chunk, then searches backwards page by page
// for the preceding chunk head, merges with that chunk if it is free, and shrinks
// the heap top if the chunk ends there. A finished result sits in an output
// register, so the next request is taken while that result waits to be collected.
// ----------------------------------------------------------------------------
// best_fit_page_allocator_unit
// Top level: controller and datapath of the page allocator.
// ----------------------------------------------------------------------------
module best_fit_page_allocator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bfpa_pkg::bfpa_req_t req_item,
  output logic                res_valid,
  input  logic                res_ready,
  output bfpa_pkg::bfpa_res_t res_item
);
  import bfpa_pkg::*;

  bfpa_cmd_t  cmd;
  bfpa_stat_t stat;

  // sequencer
  bfpa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req_item.action),
    .req_ready  (req_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // chunk table and arithmetic
  bfpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_item  (req_item),
    .cmd       (cmd),
    .stat      (stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the best-fit page allocator: allocate and free
// requests with random burst/gap timing, results compared with a local model.
// ----------------------------------------------------------------------------
module tb;
  import bfpa_pkg::*;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  bfpa_req_t req_item;
  logic      res_valid;
  logic      res_ready;
  bfpa_res_t res_item;

  best_fit_page_allocator_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
    .res_valid(res_valid), .res_ready(res_ready), .res_item(res_item)
  );

  // heap model
  int unsigned chunk_len [MAX_PAGES];
  bit          chunk_free[MAX_PAGES];
  bit          chunk_head[MAX_PAGES];
  int unsigned top_pg;

  bfpa_req_t pending_reqs[$];
  bfpa_res_t expected_res[$];
  int        mismatches;
  bit        sender_pause;
  bit        hold_off;
  int        gap_left;
  int        burst_left;

  // live start pages learnt from the model as allocates are accepted
  int unsigned live[$];

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  function automatic bfpa_res_t mk_res(logic [1:0] st, int unsigned pg);
    bfpa_res_t r;
    r.status      = st;
    r.block_page  = pg[7:0];
    r.user_offset = OFF_W'(pg * PAGE_BYTES + HEADER_BYTES);
    if (st != ST_OK || pg == 0 && st == ST_OK && 0) r.user_offset = '0;
    r.heap_top    = top_pg[8:0];
    return r;
  endfunction

  function automatic bfpa_res_t heap_alloc(int unsigned nbytes);
    int unsigned     need;
    int unsigned     p, best, plen, rest;
    bit              found;
    bfpa_res_t       r;
    need  = (nbytes + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    if (need == 0) need = 1;
    p = 0; best = 0; found = 0;
    while (p < top_pg) begin
      plen = (chunk_len[p] == 0) ? 1 : chunk_len[p];
      if (chunk_head[p] && chunk_free[p] && chunk_len[p] >= need &&
          (!found || chunk_len[p] < chunk_len[best])) begin
        best = p;
        found = 1;
      end
      p += plen;
    end
    if (found) begin
      rest = chunk_len[best] - need;
      if (longint'(rest) * PAGE_BYTES >= HEADER_BYTES + PAGE_BYTES) begin
        chunk_len[best] = need;
        if (best + need < MAX_PAGES) begin
          chunk_head[best+need] = 1;
          chunk_free[best+need] = 1;
          chunk_len[best+need]  = rest;
        end
      end
      chunk_free[best] = 0;
      return mk_res(ST_OK, best);
    end
    if (need > MAX_PAGES - top_pg) begin
      r = mk_res(ST_NOMEM, 0);
      r.user_offset = '0;
      return r;
    end
    p = top_pg;
    chunk_head[p] = 1;
    chunk_free[p] = 0;
    chunk_len[p]  = need;
    top_pg += need;
    return mk_res(ST_OK, p);
  endfunction

  function automatic bfpa_res_t heap_free(int unsigned p);
    int unsigned nx, q;
    bfpa_res_t   r;
    if (p >= top_pg || !chunk_head[p] || chunk_free[p]) begin
      r = mk_res(ST_BADFREE, 0);
      r.user_offset = '0;
      return r;
    end
    chunk_free[p] = 1;
    nx = p + chunk_len[p];
    if (nx < top_pg && nx < MAX_PAGES && chunk_head[nx] && chunk_free[nx]) begin
      chunk_len[p] += chunk_len[nx];
      chunk_head[nx] = 0;
    end
    if (p > 0) begin
      q = p;
      while (q > 0) begin
        q--;
        if (chunk_head[q]) break;
      end
      if (chunk_head[q] && chunk_free[q]) begin
        chunk_len[q] += chunk_len[p];
        chunk_head[p] = 0;
        p = q;
      end
    end
    if (p + chunk_len[p] >= top_pg) begin
      top_pg = p;
      chunk_head[p] = 0;
    end
    r = mk_res(ST_OK, 0);
    r.user_offset = '0;
    return r;
  endfunction

  // request builders
  function automatic bfpa_req_t alloc_req(int unsigned nbytes);
    bfpa_req_t q;
    q.action        = ACT_ALLOC;
    q.request_bytes = BYTES_W'(nbytes);
    q.chunk_page    = 8'($urandom);
    return q;
  endfunction

  function automatic bfpa_req_t free_req(int unsigned pg);
    bfpa_req_t q;
    q.action        = ACT_FREE;
    q.request_bytes = BYTES_W'($urandom);
    q.chunk_page    = pg[7:0];
    return q;
  endfunction

  // request driver with bursts and gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid  <= 1'b0;
      req_item   <= '0;
      gap_left   <= 0;
      burst_left <= 0;
    end else if (!req_valid || req_ready) begin
      if (gap_left > 0 || sender_pause || pending_reqs.size() == 0) begin
        req_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        req_valid <= 1'b1;
        req_item  <= pending_reqs.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(12, 1);
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // prediction on acceptance
  always @(posedge clk) begin
    bfpa_res_t r;
    if (!rst && req_valid && req_ready) begin
      if (req_item.action == ACT_ALLOC) begin
        r = heap_alloc(req_item.request_bytes);
        if (r.status == ST_OK) live.push_back(r.block_page);
      end else begin
        r = heap_free(req_item.chunk_page);
      end
      expected_res.push_back(r);
    end
  end

  // result stall pattern
  always @(posedge clk) begin
    if (rst) res_ready <= 1'b0;
    else if (hold_off) res_ready <= 1'b0;
    else res_ready <= ($urandom_range(4, 0) != 0);
  end

  // result monitor
  always @(posedge clk) begin
    bfpa_res_t e;
    if (!rst && res_valid && res_ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_item);
      end else begin
        e = expected_res.pop_front();
        if (res_item !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", e, res_item);
        end
      end
    end
  end

  // allocate/free mix from a shadow list of live chunks
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic add_random(int n);
    int k, idx;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9, 0))
        0: pending_reqs.push_back(free_req($urandom_range(255, 0)));
        1: pending_reqs.push_back(alloc_req($urandom));
        2, 3, 4: pending_reqs.push_back(alloc_req($urandom_range(3 * PAGE_BYTES, 0)));
        5: pending_reqs.push_back(alloc_req($urandom_range(40 * PAGE_BYTES, 0)));
        default: begin
          if (live.size() > 0) begin
            idx = $urandom_range(live.size() - 1, 0);
            pending_reqs.push_back(free_req(live[idx]));
            live.delete(idx);
          end else begin
            pending_reqs.push_back(alloc_req($urandom_range(PAGE_BYTES, 0)));
          end
        end
      endcase
    end
  endtask

  initial begin
    rst          = 1'b1;
    sender_pause = 1'b0;
    hold_off     = 1'b0;
    mismatches   = 0;
    top_pg       = 0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      chunk_len[i] = 0; chunk_free[i] = 0; chunk_head[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, splits, merges, bad frees, out of memory
    pending_reqs.push_back(free_req(0));
    pending_reqs.push_back(alloc_req(0));
    pending_reqs.push_back(alloc_req(PAGE_BYTES - HEADER_BYTES));
    pending_reqs.push_back(alloc_req(PAGE_BYTES - HEADER_BYTES + 1));
    pending_reqs.push_back(alloc_req(5 * PAGE_BYTES));
    pending_reqs.push_back(alloc_req(100));
    pending_reqs.push_back(free_req(1));
    pending_reqs.push_back(free_req(2));
    pending_reqs.push_back(free_req(2));
    pending_reqs.push_back(free_req(4));
    pending_reqs.push_back(alloc_req(10));
    pending_reqs.push_back(alloc_req(1048552));
    pending_reqs.push_back(alloc_req(20'hFFFFF));
    pending_reqs.push_back(alloc_req(200 * PAGE_BYTES));
    pending_reqs.push_back(alloc_req(60 * PAGE_BYTES));
    pending_reqs.push_back(free_req(255));
    pending_reqs.push_back(free_req(0));
    pending_reqs.push_back(free_req(1));
    pending_reqs.push_back(free_req(3));
    pending_reqs.push_back(free_req(9));
    pending_reqs.push_back(free_req(10));
    wait_drained();
    live.delete();
    // empty the heap using the model's view
    for (int i = 0; i < MAX_PAGES; i++)
      if (i < top_pg && chunk_head[i] && !chunk_free[i]) pending_reqs.push_back(free_req(i));
    wait_drained();

    // long receiver hold-off while requests keep coming
    add_random(40);
    hold_off = 1'b1;
    repeat (2000) @(posedge clk);
    hold_off = 1'b0;

    // sender pauses until drained
    sender_pause = 1'b1;
    while (expected_res.size() != 0) @(posedge clk);
    sender_pause = 1'b0;

    for (int b = 0; b < 10; b++) begin
      add_random(50);
      while (pending_reqs.size() > 10) @(posedge clk);
    end
    wait_drained();

    if (mismatches == 0) begin
      $display("[best_fit_page_allocator_unit] OK");
    end else begin
      $display("[best_fit_page_allocator_unit] ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(12ns * 2_000_000);
    $display("[best_fit_page_allocator_unit] ERROR");
    $finish;
  end

endmodule
